[src/modular_power_inverse_discrete_log_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modular power / inverse / discrete log core
// Concurrent checks sampled on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MODULAR_POWER_INVERSE_DISCRETE_LOG_CORE_ASSERT_SVH
`define MODULAR_POWER_INVERSE_DISCRETE_LOG_CORE_ASSERT_SVH

// same-cycle implication
`define MPIDL_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MPIDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/mpidl_pkg.sv]
// ----------------------------------------------------------------------------
// mpidl_pkg
// Shared widths, mode codes and table request and response types.
// ----------------------------------------------------------------------------
package mpidl_pkg;

  localparam int VAL_W  = 31;
  localparam int IDX_W  = 16;
  localparam int ROOT_W = 16;

  localparam logic [1:0] MODE_POW = 2'd1;
  localparam logic [1:0] MODE_DIV = 2'd2;

  typedef enum logic [1:0] {
    TBL_CLEAR,
    TBL_PUT,
    TBL_GET
  } tbl_op_t;

  typedef struct packed {
    logic    start;
    tbl_op_t op;
  } tbl_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } tbl_rsp_t;

endpackage

[src/modular_power_inverse_discrete_log_core.sv]
// ----------------------------------------------------------------------------
// modular_power_inverse_discrete_log_core
// Modular power, Fermat division and baby-step giant-step discrete log,
// sequenced over one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   in_valid in_ready base operand modulus    in
//  result    out_valid out_ready answer no_solution    out
//  config    cfg_we cfg_data (mode)                    in
//
//  Each modular product runs in the shared multiplier; a query stays busy
//  for all of its products: up to 2 * 31 products plus the operand
//  reductions (and, for division, the final product) for power and division,
//  and for the log a clear sweep over all TABLE_DEPTH table slots plus about
//  2 * sqrt(p) products and probes. rst clears control state; the table is
//  swept at the start of each log. in_ready is high only while idle; a
//  result held for out_ready does not block the next request.
// ----------------------------------------------------------------------------
module modular_power_inverse_discrete_log_core import mpidl_pkg::*; #(
  parameter int TABLE_DEPTH = 65536,
  parameter int MOD_BITS    = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] base,
  input  logic [VAL_W-1:0] operand,
  input  logic [VAL_W-1:0] modulus,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] answer,
  output logic             no_solution,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data
);

  localparam logic [VAL_W-1:0] MASK = VAL_W'((64'd1 << MOD_BITS) - 64'd1);

  typedef enum logic [4:0] {
    S_IDLE, S_YRED, S_M1, S_ZRED2, S_M2A, S_M2B, S_SQRT, S_CLR, S_ZR3,
    S_BS0, S_BS, S_BSP, S_GS0, S_GS, S_GSP, S_GSC, S_GSR,
    S_POW, S_POW_A, S_POW_S, S_MWAIT, S_TWAIT, S_FIN
  } state_t;

  state_t            state;
  state_t            mret;
  state_t            tret;
  state_t            pret;
  logic [1:0]        mode;
  logic [VAL_W-1:0]  lz;
  logic [VAL_W-1:0]  lp;
  logic [VAL_W-1:0]  y;
  logic [VAL_W-1:0]  zr;
  logic [VAL_W-1:0]  cur;
  logic [VAL_W-1:0]  giant;
  logic [VAL_W-1:0]  res;
  logic              ok;
  logic [ROOT_W-1:0] root;
  logic [3:0]        sq_bit;
  logic [IDX_W-1:0]  cnt;
  logic [VAL_W-1:0]  pw_acc;
  logic [VAL_W-1:0]  pw_sq;
  logic [VAL_W-1:0]  pw_e;
  logic              mul_start;
  logic [VAL_W-1:0]  mul_a;
  logic [VAL_W-1:0]  mul_b;
  logic              mul_done;
  logic [VAL_W-1:0]  mul_res;
  tbl_req_t          tbl_req;
  tbl_rsp_t          tbl_rsp;
  logic [VAL_W-1:0]  tb_key;
  logic [IDX_W-1:0]  tb_idx;
  logic [IDX_W-1:0]  tbl_found_idx;
  logic [ROOT_W-1:0] cand;
  logic [2*ROOT_W-1:0] cand_sq;
  logic [VAL_W+1:0]  gs_sum;
  logic [VAL_W+1:0]  gs_fix;

  assign in_ready = (state == S_IDLE);
  assign cand     = root | (ROOT_W'(1) << sq_bit);
  assign cand_sq  = cand * cand;
  assign gs_sum   = (VAL_W+2)'(mul_res) + (VAL_W+2)'(lp) - (VAL_W+2)'(tbl_found_idx);
  assign gs_fix   = (gs_sum >= (VAL_W+2)'(lp)) ? gs_sum - (VAL_W+2)'(lp) : gs_sum;

  mpidl_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (lp),
    .done  (mul_done),
    .result(mul_res)
  );

  mpidl_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_tbl (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .key      (tb_key),
    .idx      (tb_idx),
    .rsp      (tbl_rsp),
    .found_idx(tbl_found_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_POW;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      tbl_req   <= '{start: 1'b0, op: TBL_CLEAR};
    end else begin
      mul_start     <= 1'b0;
      tbl_req.start <= 1'b0;
      if (cfg_we) begin
        mode <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            lz <= operand & MASK;
            lp <= modulus & MASK;
            ok <= 1'b0;
            if ((modulus & MASK) < VAL_W'(2)) begin
              state <= S_FIN;
            end else begin
              mul_a     <= base & MASK;
              mul_b     <= VAL_W'(1);
              mul_start <= 1'b1;
              mret      <= S_YRED;
              state     <= S_MWAIT;
            end
          end
        end
        S_YRED: begin
          y <= mul_res;
          case (mode)
            MODE_POW: begin
              pw_acc <= VAL_W'(1);
              pw_sq  <= mul_res;
              pw_e   <= lz;
              pret   <= S_M1;
              state  <= S_POW;
            end
            MODE_DIV: begin
              mul_a     <= lz;
              mul_b     <= VAL_W'(1);
              mul_start <= 1'b1;
              mret      <= S_ZRED2;
              state     <= S_MWAIT;
            end
            default: begin
              if (mul_res == '0) begin
                ok    <= (lz == '0);
                res   <= VAL_W'(1);
                state <= S_FIN;
              end else begin
                root   <= '0;
                sq_bit <= 4'(ROOT_W - 1);
                state  <= S_SQRT;
              end
            end
          endcase
        end
        S_M1: begin
          res   <= pw_acc;
          ok    <= 1'b1;
          state <= S_FIN;
        end
        S_ZRED2: begin
          zr <= mul_res;
          if (y == '0 && mul_res != '0) begin
            state <= S_FIN;
          end else begin
            pw_acc <= VAL_W'(1);
            pw_sq  <= y;
            pw_e   <= lp - VAL_W'(2);
            pret   <= S_M2A;
            state  <= S_POW;
          end
        end
        S_M2A: begin
          mul_a     <= zr;
          mul_b     <= pw_acc;
          mul_start <= 1'b1;
          mret      <= S_M2B;
          state     <= S_MWAIT;
        end
        S_M2B: begin
          res   <= mul_res;
          ok    <= 1'b1;
          state <= S_FIN;
        end
        S_SQRT: begin
          if (cand_sq <= {1'b0, lp}) begin
            root <= cand;
          end
          if (sq_bit == '0) begin
            state <= S_CLR;
          end else begin
            sq_bit <= sq_bit - 4'd1;
          end
        end
        S_CLR: begin
          tbl_req <= '{start: 1'b1, op: TBL_CLEAR};
          tret    <= S_ZR3;
          state   <= S_TWAIT;
        end
        S_ZR3: begin
          mul_a     <= lz;
          mul_b     <= VAL_W'(1);
          mul_start <= 1'b1;
          mret      <= S_BS0;
          state     <= S_MWAIT;
        end
        S_BS0: begin
          cur     <= mul_res;
          cnt     <= '0;
          tb_key  <= mul_res;
          tb_idx  <= '0;
          tbl_req <= '{start: 1'b1, op: TBL_PUT};
          tret    <= S_BS;
          state   <= S_TWAIT;
        end
        S_BS: begin
          if (cnt == root) begin
            pw_acc <= VAL_W'(1);
            pw_sq  <= y;
            pw_e   <= VAL_W'(root);
            pret   <= S_GS0;
            state  <= S_POW;
          end else begin
            cnt       <= cnt + 1'b1;
            mul_a     <= cur;
            mul_b     <= y;
            mul_start <= 1'b1;
            mret      <= S_BSP;
            state     <= S_MWAIT;
          end
        end
        S_BSP: begin
          cur     <= mul_res;
          tb_key  <= mul_res;
          tb_idx  <= cnt;
          tbl_req <= '{start: 1'b1, op: TBL_PUT};
          tret    <= S_BS;
          state   <= S_TWAIT;
        end
        S_GS0: begin
          giant <= pw_acc;
          cur   <= VAL_W'(1);
          cnt   <= '0;
          state <= S_GS;
        end
        S_GS: begin
          if (cnt == root) begin
            state <= S_FIN;
          end else begin
            cnt       <= cnt + 1'b1;
            mul_a     <= cur;
            mul_b     <= giant;
            mul_start <= 1'b1;
            mret      <= S_GSP;
            state     <= S_MWAIT;
          end
        end
        S_GSP: begin
          cur     <= mul_res;
          tb_key  <= mul_res;
          tbl_req <= '{start: 1'b1, op: TBL_GET};
          tret    <= S_GSC;
          state   <= S_TWAIT;
        end
        S_GSC: begin
          if (tbl_rsp.found) begin
            mul_a     <= VAL_W'(cnt);
            mul_b     <= VAL_W'(root);
            mul_start <= 1'b1;
            mret      <= S_GSR;
            state     <= S_MWAIT;
          end else begin
            state <= S_GS;
          end
        end
        S_GSR: begin
          res   <= gs_fix[VAL_W-1:0];
          ok    <= 1'b1;
          state <= S_FIN;
        end
        S_POW: begin
          if (pw_e == '0) begin
            state <= pret;
          end else if (pw_e[0]) begin
            mul_a     <= pw_acc;
            mul_b     <= pw_sq;
            mul_start <= 1'b1;
            mret      <= S_POW_A;
            state     <= S_MWAIT;
          end else begin
            mul_a     <= pw_sq;
            mul_b     <= pw_sq;
            mul_start <= 1'b1;
            mret      <= S_POW_S;
            state     <= S_MWAIT;
          end
        end
        S_POW_A: begin
          pw_acc    <= mul_res;
          mul_a     <= pw_sq;
          mul_b     <= pw_sq;
          mul_start <= 1'b1;
          mret      <= S_POW_S;
          state     <= S_MWAIT;
        end
        S_POW_S: begin
          pw_sq <= mul_res;
          pw_e  <= pw_e >> 1;
          state <= S_POW;
        end
        S_MWAIT: begin
          if (mul_done) begin
            state <= mret;
          end
        end
        S_TWAIT: begin
          if (tbl_rsp.done) begin
            state <= tret;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            answer      <= ok ? res : '0;
            no_solution <= !ok;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "modular_power_inverse_discrete_log_core_assert.svh"

  `MPIDL_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request not held busy")
  `MPIDL_ASSERT_IMPLIES(a_fail_zero, out_valid && no_solution, answer == '0, "failed answer nonzero")
  `MPIDL_ASSERT_IMPLIES(a_rose_after_busy, $rose(out_valid), $past(!in_ready), "result without work")

endmodule

[src/mpidl_ram.sv]
// ----------------------------------------------------------------------------
// mpidl_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mpidl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/mpidl_mulmod.sv]
// ----------------------------------------------------------------------------
// mpidl_mulmod
// Bit-serial modular multiplier: result = a * b mod p, one bit of a per cycle.
// b must be below p; a may be any value.
// ----------------------------------------------------------------------------
module mpidl_mulmod import mpidl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  input  logic [VAL_W-1:0] p,
  output logic             done,
  output logic [VAL_W-1:0] result
);

  logic             busy;
  logic [4:0]       cnt;
  logic [VAL_W-1:0] sh;
  logic [VAL_W-1:0] acc;
  logic [VAL_W:0]   dbl;
  logic [VAL_W:0]   dbl_r;
  logic [VAL_W:0]   sum;
  logic [VAL_W:0]   sum_r;

  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    sum   = {1'b0, dbl_r[VAL_W-1:0]} + (sh[VAL_W-1] ? {1'b0, b} : '0);
    sum_r = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
  end

  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc  <= '0;
        sh   <= a;
        cnt  <= 5'(VAL_W - 1);
      end else if (busy) begin
        acc <= sum_r[VAL_W-1:0];
        sh  <= sh << 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

[src/mpidl_table.sv]
// ----------------------------------------------------------------------------
// mpidl_table
// Linear-probe hash table of baby steps (residue -> index) with a clear sweep.
// DEPTH must be a power of two; the home slot is the low bits of the key.
// ----------------------------------------------------------------------------
module mpidl_table import mpidl_pkg::*; #(
  parameter int DEPTH = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  tbl_req_t         req,
  input  logic [VAL_W-1:0] key,
  input  logic [IDX_W-1:0] idx,
  output tbl_rsp_t         rsp,
  output logic [IDX_W-1:0] found_idx
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ENT_W  = 1 + IDX_W + VAL_W;

  typedef enum logic [1:0] {
    T_IDLE,
    T_CLR,
    T_RD,
    T_CHK
  } tstate_t;

  tstate_t           state;
  tbl_op_t           op;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] n;
  logic              ram_we;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  logic              r_valid;
  logic [IDX_W-1:0]  r_idx;
  logic [VAL_W-1:0]  r_key;
  logic              hit;

  assign r_valid = ram_rdata[ENT_W-1];
  assign r_idx   = ram_rdata[VAL_W+IDX_W-1:VAL_W];
  assign r_key   = ram_rdata[VAL_W-1:0];
  assign hit     = r_valid && (r_key == key);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state)
      T_CLR: begin
        ram_we = 1'b1;
      end
      T_CHK: begin
        ram_we    = (op == TBL_PUT) && (!r_valid || hit);
        ram_wdata = {1'b1, idx, key};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mpidl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (slot),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      rsp   <= '0;
      op    <= TBL_CLEAR;
      slot  <= '0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (req.start) begin
            op        <= req.op;
            n         <= '0;
            rsp.found <= 1'b0;
            if (req.op == TBL_CLEAR) begin
              slot  <= '0;
              state <= T_CLR;
            end else begin
              slot  <= key[ADDR_W-1:0];
              state <= T_RD;
            end
          end
        end
        T_CLR: begin
          slot <= slot + 1'b1;
          if (&slot) begin
            rsp.done <= 1'b1;
            state    <= T_IDLE;
          end
        end
        T_RD: begin
          state <= T_CHK;
        end
        T_CHK: begin
          if (!r_valid || hit) begin
            rsp.found <= (op == TBL_GET) && hit;
            found_idx <= r_idx;
            rsp.done  <= 1'b1;
            state     <= T_IDLE;
          end else if (&n) begin
            rsp.done <= 1'b1;
            state    <= T_IDLE;
          end else begin
            slot  <= slot + 1'b1;
            n     <= n + 1'b1;
            state <= T_RD;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule
